### hw/rtl/spl_pkg.sv
// Shared types, codes and keyword tables of the PHP span lexer.
package spl_pkg;

    localparam int KW_CHARS = 15;

    localparam logic KIND_SPAN = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    localparam logic [2:0] ST_COMMENT  = 3'd0;
    localparam logic [2:0] ST_STRING   = 3'd1;
    localparam logic [2:0] ST_VARIABLE = 3'd2;
    localparam logic [2:0] ST_KEYWORD  = 3'd3;
    localparam logic [2:0] ST_TYPE     = 3'd4;
    localparam logic [2:0] ST_FUNCTION = 3'd5;

    localparam logic [1:0] CM_NORMAL  = 2'd0;
    localparam logic [1:0] CM_COMMENT = 2'd1;
    localparam logic [1:0] CM_DQ      = 2'd2;
    localparam logic [1:0] CM_SQ      = 2'd3;

    localparam logic [20:0] CH_NL     = 21'd10;
    localparam logic [20:0] CH_TAB    = 21'd9;
    localparam logic [20:0] CH_SPACE  = 21'd32;
    localparam logic [20:0] CH_DOLLAR = 21'd36;
    localparam logic [20:0] CH_EQ     = 21'd61;
    localparam logic [20:0] CH_LPAR   = 21'd40;
    localparam logic [20:0] CH_RPAR   = 21'd41;
    localparam logic [20:0] CH_STAR   = 21'd42;
    localparam logic [20:0] CH_SLASH  = 21'd47;
    localparam logic [20:0] CH_BSLASH = 21'd92;
    localparam logic [20:0] CH_DQUOTE = 21'd34;
    localparam logic [20:0] CH_SQUOTE = 21'd39;

    typedef struct packed {
        logic        kind;
        logic [15:0] span_start;
        logic [15:0] span_len;
        logic [2:0]  style;
        logic [1:0]  end_state;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [1:0] n;
        rec_t       r0;
        rec_t       r1;
    } push_t;

    // Character i of the buffer sits at bits [8*i +: 8]; a word literal is
    // right-justified, so its character i sits at position wl-1-i.
    function automatic logic word_eq(logic [KW_CHARS*8-1:0] chars, logic [4:0] n,
                                     logic [KW_CHARS*8-1:0] w, logic [4:0] wl);
        logic ok;
        ok = (n == wl);
        for (int i = 0; i < KW_CHARS; i++) begin
            if (5'(i) < wl) begin
                if (chars[8*i +: 8] != w[8*(int'(wl)-1-i) +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    function automatic logic is_kw(logic [KW_CHARS*8-1:0] c, logic [4:0] n);
        logic m;
        m = 1'b0;
        m |= word_eq(c, n, {"__halt", "_compiler"}, 5'd15);
        m |= word_eq(c, n, "abstract", 5'd8);
        m |= word_eq(c, n, "and", 5'd3);
        m |= word_eq(c, n, "as", 5'd2);
        m |= word_eq(c, n, "break", 5'd5);
        m |= word_eq(c, n, "callable", 5'd8);
        m |= word_eq(c, n, "case", 5'd4);
        m |= word_eq(c, n, "catch", 5'd5);
        m |= word_eq(c, n, "class", 5'd5);
        m |= word_eq(c, n, "clone", 5'd5);
        m |= word_eq(c, n, "const", 5'd5);
        m |= word_eq(c, n, "continue", 5'd8);
        m |= word_eq(c, n, "declare", 5'd7);
        m |= word_eq(c, n, "default", 5'd7);
        m |= word_eq(c, n, "die", 5'd3);
        m |= word_eq(c, n, "do", 5'd2);
        m |= word_eq(c, n, "echo", 5'd4);
        m |= word_eq(c, n, "else", 5'd4);
        m |= word_eq(c, n, "elseif", 5'd6);
        m |= word_eq(c, n, "empty", 5'd5);
        m |= word_eq(c, n, "enddeclare", 5'd10);
        m |= word_eq(c, n, "endfor", 5'd6);
        m |= word_eq(c, n, "endforeach", 5'd10);
        m |= word_eq(c, n, "endif", 5'd5);
        m |= word_eq(c, n, "endswitch", 5'd9);
        m |= word_eq(c, n, "endwhile", 5'd8);
        m |= word_eq(c, n, "eval", 5'd4);
        m |= word_eq(c, n, "exit", 5'd4);
        m |= word_eq(c, n, "extends", 5'd7);
        m |= word_eq(c, n, "final", 5'd5);
        m |= word_eq(c, n, "for", 5'd3);
        m |= word_eq(c, n, "foreach", 5'd7);
        m |= word_eq(c, n, "function", 5'd8);
        m |= word_eq(c, n, "global", 5'd6);
        m |= word_eq(c, n, "goto", 5'd4);
        m |= word_eq(c, n, "if", 5'd2);
        m |= word_eq(c, n, "implements", 5'd10);
        m |= word_eq(c, n, "include", 5'd7);
        m |= word_eq(c, n, {"include", "_once"}, 5'd12);
        m |= word_eq(c, n, "instanceof", 5'd10);
        m |= word_eq(c, n, "insteadof", 5'd9);
        m |= word_eq(c, n, "interface", 5'd9);
        m |= word_eq(c, n, "isset", 5'd5);
        m |= word_eq(c, n, "list", 5'd4);
        m |= word_eq(c, n, "namespace", 5'd9);
        m |= word_eq(c, n, "new", 5'd3);
        m |= word_eq(c, n, "or", 5'd2);
        m |= word_eq(c, n, "print", 5'd5);
        m |= word_eq(c, n, "private", 5'd7);
        m |= word_eq(c, n, "protected", 5'd9);
        m |= word_eq(c, n, "public", 5'd6);
        m |= word_eq(c, n, "require", 5'd7);
        m |= word_eq(c, n, {"require", "_once"}, 5'd12);
        m |= word_eq(c, n, "return", 5'd6);
        m |= word_eq(c, n, "static", 5'd6);
        m |= word_eq(c, n, "switch", 5'd6);
        m |= word_eq(c, n, "throw", 5'd5);
        m |= word_eq(c, n, "trait", 5'd5);
        m |= word_eq(c, n, "try", 5'd3);
        m |= word_eq(c, n, "use", 5'd3);
        m |= word_eq(c, n, "var", 5'd3);
        m |= word_eq(c, n, "while", 5'd5);
        m |= word_eq(c, n, "xor", 5'd3);
        return m;
    endfunction

    function automatic logic is_ty(logic [KW_CHARS*8-1:0] c, logic [4:0] n);
        logic m;
        m = 1'b0;
        m |= word_eq(c, n, "int", 5'd3);
        m |= word_eq(c, n, "integer", 5'd7);
        m |= word_eq(c, n, "bool", 5'd4);
        m |= word_eq(c, n, "boolean", 5'd7);
        m |= word_eq(c, n, "float", 5'd5);
        m |= word_eq(c, n, "double", 5'd6);
        m |= word_eq(c, n, "real", 5'd4);
        m |= word_eq(c, n, "string", 5'd6);
        m |= word_eq(c, n, "array", 5'd5);
        m |= word_eq(c, n, "object", 5'd6);
        m |= word_eq(c, n, "unset", 5'd5);
        m |= word_eq(c, n, "NULL", 5'd4);
        return m;
    endfunction

endpackage

### hw/rtl/php_syntax_span_lexer.sv
// Top level of the PHP colour-span lexer: front end, result queue, back end.
// Path: the result words of a character are written to the queue when the character is
// taken and reach the output through the output register; a newline's second word follows.
// Throughput: one character per cycle while the queue has room for two words; output
// drains one word per cycle while out_ready is high, so newlines can briefly hold off input.
// Reset: rst_n clears the lexer state, the queue pointers and the output valid
// at once; no clearing pass is needed and the block takes a character next cycle.
module php_syntax_span_lexer #(
    parameter int KEY_CHARS = 32,
    parameter int COL_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [20:0] ch,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [15:0] span_start,
    output logic [15:0] span_len,
    output logic [2:0]  style,
    output logic [1:0]  end_state,
    output logic        last
);
    import spl_pkg::*;

    push_t push;
    logic  room, q_valid, pop;
    rec_t  q_data, out_data;

    // A character is taken only while the queue can absorb the two words
    // a newline may produce, so the front end never has to stall mid-word.
    assign in_ready = room;

    spl_front #(
        .KEY_CHARS(KEY_CHARS),
        .COL_BITS (COL_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .ch    (ch),
        .accept(in_valid && room),
        .push  (push)
    );

    spl_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .q_valid(q_valid),
        .q_data (q_data),
        .pop    (pop)
    );

    spl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .out_ready(out_ready),
        .out_valid(out_valid),
        .out_data (out_data)
    );

    // Each result word is unpacked onto its own field ports.
    assign kind       = out_data.kind;
    assign span_start = out_data.span_start;
    assign span_len   = out_data.span_len;
    assign style      = out_data.style;
    assign end_state  = out_data.end_state;
    assign last       = out_data.last;

endmodule

### hw/rtl/spl_front.sv
// Front end: accepts characters, runs the lexer state and forms result words.
module spl_front #(
    parameter int KEY_CHARS = 32,
    parameter int COL_BITS  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [20:0]   ch,
    input  logic          accept,
    output spl_pkg::push_t push
);
    import spl_pkg::*;

    localparam int DEPTH = KEY_CHARS - 1;
    localparam int IB    = $clog2(DEPTH);
    localparam int CB    = $clog2(KEY_CHARS + 1);
    localparam logic [COL_BITS-1:0] COL_MAX = {COL_BITS{1'b1}};

    typedef enum logic [3:0] {
        PH_SCAN, PH_SLASH, PH_BLOCK, PH_LINE, PH_DQ, PH_SQ, PH_VAR, PH_IDENT, PH_LOOK
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [1:0]          cm_reg, cm_next;
    logic                ps_reg, ps_next;
    logic                esc_reg, esc_next;
    logic                td_reg, td_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [COL_BITS-1:0] ts_reg, ts_next;
    logic [COL_BITS-1:0] ie_reg, ie_next;
    logic [CB-1:0]       cnt_reg, cnt_next;
    logic [7:0]          buf_reg [DEPTH];

    logic                wr_en;
    logic [IB-1:0]       wr_idx;
    logic [KW_CHARS*8-1:0] pre;
    logic [4:0]          n5;
    logic                fits, kw, ty;

    function automatic logic [15:0] sat16(logic [COL_BITS-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'd65535) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic alpha(logic [20:0] c);
        return (c >= 21'd97 && c <= 21'd122) || (c >= 21'd65 && c <= 21'd90) ||
               c == 21'd95;
    endfunction

    always_comb
    begin
        for (int i = 0; i < KW_CHARS; i++) begin
            pre[8*i +: 8] = buf_reg[i];
        end
        n5   = (cnt_reg > CB'(KW_CHARS)) ? 5'(KW_CHARS + 1) : 5'(cnt_reg);
        fits = cnt_reg <= CB'(DEPTH);
        kw   = fits && is_kw(pre, n5);
        ty   = fits && is_ty(pre, n5);
    end

    always_comb
    begin
        logic                span_v, do_dec, do_disp, nl, ws, at0;
        logic [2:0]          span_style;
        logic [COL_BITS-1:0] span_end, col1;
        rec_t                sp, eol;

        phase_next = phase_reg;
        cm_next    = cm_reg;
        ps_next    = ps_reg;
        esc_next   = esc_reg;
        td_next    = td_reg;
        col_next   = col_reg;
        ts_next    = ts_reg;
        ie_next    = ie_reg;
        cnt_next   = cnt_reg;
        wr_en      = 1'b0;
        wr_idx     = cnt_reg[IB-1:0];
        span_v     = 1'b0;
        span_style = ST_COMMENT;
        span_end   = col_reg;
        do_dec     = 1'b0;
        do_disp    = 1'b0;
        nl         = (ch == CH_NL);
        ws         = (ch == CH_SPACE) || (ch == CH_TAB);
        at0        = (ts_reg == '0);
        col1       = (col_reg == COL_MAX) ? col_reg : col_reg + 1'b1;

        if (nl) begin
            case (phase_reg)
                PH_BLOCK, PH_LINE:
                begin
                    span_v = 1'b1;
                    span_style = ST_COMMENT;
                end
                PH_DQ, PH_SQ:
                begin
                    span_v = 1'b1;
                    span_style = ST_STRING;
                end
                PH_VAR:
                begin
                    span_v = 1'b1;
                    span_style = ST_VARIABLE;
                end
                PH_IDENT:
                begin
                    ie_next = col_reg;
                    do_dec = 1'b1;
                end
                PH_LOOK: do_dec = 1'b1;
                default: ;
            endcase
        end else begin
            case (phase_reg)
                PH_SLASH:
                begin
                    if (ch == CH_STAR) begin
                        phase_next = PH_BLOCK;
                        cm_next = CM_COMMENT;
                        ps_next = 1'b0;
                    end else if (ch == CH_SLASH) begin
                        phase_next = PH_LINE;
                    end else begin
                        do_disp = 1'b1;
                    end
                end
                PH_BLOCK:
                begin
                    if (ps_reg && ch == CH_SLASH) begin
                        span_v = 1'b1;
                        span_style = ST_COMMENT;
                        span_end = col1;
                        phase_next = PH_SCAN;
                        cm_next = CM_NORMAL;
                        ps_next = 1'b0;
                    end else begin
                        ps_next = (ch == CH_STAR);
                    end
                end
                PH_LINE: ;
                PH_DQ, PH_SQ:
                begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                    end else if (ch == CH_BSLASH) begin
                        esc_next = 1'b1;
                    end else if ((ch == CH_DQUOTE && phase_reg == PH_DQ) ||
                                 (ch == CH_SQUOTE && phase_reg == PH_SQ)) begin
                        span_v = 1'b1;
                        span_style = ST_STRING;
                        span_end = col1;
                        phase_next = PH_SCAN;
                        cm_next = CM_NORMAL;
                    end
                end
                PH_VAR:
                begin
                    if (!alpha(ch)) begin
                        span_v = 1'b1;
                        span_style = ST_VARIABLE;
                        do_disp = 1'b1;
                    end
                end
                PH_IDENT:
                begin
                    if (alpha(ch) || (ch >= 21'd48 && ch <= 21'd57)) begin
                        wr_en = cnt_reg < CB'(DEPTH);
                        if (cnt_reg < CB'(KEY_CHARS)) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end else begin
                        ie_next = col_reg;
                        phase_next = PH_LOOK;
                        if (!ws) begin
                            do_dec = 1'b1;
                            do_disp = 1'b1;
                        end
                    end
                end
                PH_LOOK:
                begin
                    if (!ws) begin
                        do_dec = 1'b1;
                        do_disp = 1'b1;
                    end
                end
                default: do_disp = 1'b1;
            endcase
        end

        // Identifier classification; the type-declaration flag is updated
        // before the dispatch of the same character can clear it.
        if (do_dec) begin
            span_end = ie_next;
            if (kw) begin
                span_v = 1'b1;
                span_style = ST_KEYWORD;
            end else if (ty) begin
                span_v = 1'b1;
                span_style = ST_TYPE;
                if (ch != CH_RPAR) begin
                    td_next = 1'b1;
                end
            end else begin
                if (at0) begin
                    td_next = 1'b1;
                end
                if (td_next) begin
                    span_v = 1'b1;
                    if (ch == CH_LPAR) begin
                        span_style = ST_FUNCTION;
                    end else if (at0) begin
                        span_style = ST_TYPE;
                    end else begin
                        span_style = ST_VARIABLE;
                    end
                end
            end
        end

        if (do_disp) begin
            phase_next = PH_SCAN;
            if (ch == CH_SLASH) begin
                phase_next = PH_SLASH;
                ts_next = col_reg;
            end else if (ch == CH_DOLLAR) begin
                phase_next = PH_VAR;
                ts_next = col_reg;
            end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
                phase_next = (ch == CH_DQUOTE) ? PH_DQ : PH_SQ;
                cm_next = (ch == CH_DQUOTE) ? CM_DQ : CM_SQ;
                esc_next = 1'b0;
                ts_next = col_reg;
            end else if (ch == CH_EQ) begin
                td_next = 1'b0;
            end else if (alpha(ch)) begin
                phase_next = PH_IDENT;
                ts_next = col_reg;
                wr_en = 1'b1;
                wr_idx = '0;
                cnt_next = CB'(1);
            end
        end

        if (nl) begin
            if (phase_reg != PH_BLOCK && phase_reg != PH_DQ && phase_reg != PH_SQ) begin
                phase_next = PH_SCAN;
            end
            ps_next  = 1'b0;
            esc_next = 1'b0;
            td_next  = 1'b0;
            ts_next  = '0;
            col_next = '0;
        end else begin
            col_next = col1;
        end

        sp.kind       = KIND_SPAN;
        sp.span_start = sat16(ts_reg);
        sp.span_len   = sat16((span_end >= ts_reg) ? span_end - ts_reg : '0);
        sp.style      = span_style;
        sp.end_state  = CM_NORMAL;
        sp.last       = !nl;
        eol.kind       = KIND_EOL;
        eol.span_start = '0;
        eol.span_len   = '0;
        eol.style      = ST_COMMENT;
        eol.end_state  = cm_reg;
        eol.last       = 1'b1;

        push.r1 = eol;
        if (nl) begin
            push.n  = span_v ? 2'd2 : 2'd1;
            push.r0 = span_v ? sp : eol;
        end else begin
            push.n  = span_v ? 2'd1 : 2'd0;
            push.r0 = sp;
        end
        if (!accept) begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_SCAN;
            cm_reg    <= CM_NORMAL;
            ps_reg    <= 1'b0;
            esc_reg   <= 1'b0;
            td_reg    <= 1'b0;
            col_reg   <= '0;
            ts_reg    <= '0;
            ie_reg    <= '0;
            cnt_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cm_reg    <= cm_next;
            ps_reg    <= ps_next;
            esc_reg   <= esc_next;
            td_reg    <= td_next;
            col_reg   <= col_next;
            ts_reg    <= ts_next;
            ie_reg    <= ie_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en) begin
            buf_reg[wr_idx] <= ch[7:0];
        end
    end

endmodule

### hw/rtl/spl_queue.sv
// Four-entry result queue: up to two words in, one word out per cycle.
module spl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  spl_pkg::push_t push,
    output logic           room,
    output logic           q_valid,
    output spl_pkg::rec_t  q_data,
    input  logic           pop
);
    import spl_pkg::*;

    rec_t       mem_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg, cnt_next;

    assign room    = cnt_reg <= 3'd2;
    assign q_valid = cnt_reg != 3'd0;
    assign q_data  = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 3'(push.n) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            rd_reg  <= rd_reg + 2'(pop);
            wr_reg  <= wr_reg + push.n;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0) begin
            mem_reg[wr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_reg + 2'd1] <= push.r1;
        end
    end

endmodule

### hw/rtl/spl_back.sv
// Back end: output register that presents one result word to the consumer.
module spl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  spl_pkg::rec_t q_data,
    output logic          pop,
    input  logic          out_ready,
    output logic          out_valid,
    output spl_pkg::rec_t out_data
);
    import spl_pkg::*;

    logic ov_reg;
    rec_t od_reg;

    assign pop       = q_valid && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ov_reg <= 1'b0;
        end else if (!ov_reg || out_ready) begin
            ov_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            od_reg <= q_data;
        end
    end

endmodule

### hw/rtl/spl_checker.sv
// Port-level checks of the span lexer and their binding to the top level.
module spl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        kind,
    input logic [15:0] span_start,
    input logic [15:0] span_len,
    input logic [2:0]  style,
    input logic [1:0]  end_state,
    input logic        last
);
    import spl_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(span_start) &&
        $stable(span_len) && $stable(kind) && $stable(last))
        else $error("stalled output word changed");

    a_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EOL |-> span_start == 16'd0 && span_len == 16'd0 &&
        style == ST_COMMENT && last)
        else $error("end-of-line word carries span fields");

    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SPAN |-> end_state == CM_NORMAL && style <= ST_FUNCTION)
        else $error("span word has bad style or end state");

    a_rst: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind php_syntax_span_lexer spl_checker u_spl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .span_start(span_start),
    .span_len  (span_len),
    .style     (style),
    .end_state (end_state),
    .last      (last)
);

### bench/span_checker.sv
// Span checker: predicts the lexer's output words from the accepted characters and compares them.
module span_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [20:0] ch,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        kind,
    input  logic [15:0] span_start,
    input  logic [15:0] span_len,
    input  logic [2:0]  style,
    input  logic [1:0]  end_state,
    input  logic        last,
    output int          errors,
    output int          pending
);
    import spl_pkg::*;

    typedef enum logic [3:0] {
        LX_SCAN, LX_SLASH, LX_BLOCK, LX_LINE, LX_DQ, LX_SQ, LX_VAR, LX_IDENT, LX_LOOK
    } lex_phase_t;

    localparam logic [15:0] COL_TOP = 16'hFFFF;
    localparam int BUF_CHARS = 31;

    string keywords [63] = '{
        {"__halt", "_compiler"}, "abstract", "and", "as", "break", "callable", "case",
        "catch", "class", "clone", "const", "continue", "declare", "default",
        "die", "do", "echo", "else", "elseif", "empty", "enddeclare", "endfor",
        "endforeach", "endif", "endswitch", "endwhile", "eval", "exit",
        "extends", "final", "for", "foreach", "function", "global", "goto", "if",
        "implements", "include", {"include", "_once"}, "instanceof", "insteadof",
        "interface", "isset", "list", "namespace", "new", "or", "print",
        "private", "protected", "public", "require", {"require", "_once"}, "return",
        "static", "switch", "throw", "trait", "try", "use", "var", "while", "xor"
    };
    string type_names [12] = '{
        "int", "integer", "bool", "boolean", "float", "double", "real",
        "string", "array", "object", "unset", "NULL"
    };

    logic [1:0]  carry_mode;
    lex_phase_t  phase;
    bit          star_seen;
    bit          escaping;
    logic [15:0] col;
    logic [15:0] tok_start;
    logic [15:0] word_end;
    logic [7:0]  word_buf [BUF_CHARS];
    int          word_len;
    bit          decl_line;

    rec_t step_words [$];
    rec_t spans_due [$];

    function automatic bit is_letter(logic [20:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // Exact, case-sensitive match of the buffered identifier against one list.
    function automatic bit word_listed(bit types);
        int n;
        bit hit;
        string w;
        n = types ? 12 : 63;
        for (int k = 0; k < n; k++) begin
            w = types ? type_names[k] : keywords[k];
            if (w.len() == word_len) begin
                hit = 1'b1;
                for (int i = 0; i < word_len; i++) begin
                    if (w[i] != word_buf[i]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic add_word(logic kd, logic [15:0] start, logic [15:0] len,
                            logic [2:0] sty, logic [1:0] es);
        rec_t r;
        r.kind = kd;
        r.span_start = start;
        r.span_len = len;
        r.style = sty;
        r.end_state = es;
        r.last = 1'b0;
        step_words.push_back(r);
    endtask

    task automatic add_span(logic [15:0] stop, logic [2:0] sty);
        add_word(KIND_SPAN, tok_start, stop >= tok_start ? stop - tok_start : 16'd0, sty,
                 CM_NORMAL);
    endtask

    task automatic add_char(logic [20:0] c);
        if (word_len < BUF_CHARS) begin
            word_buf[word_len] = c[7:0];
        end
        if (word_len < BUF_CHARS + 1) begin
            word_len++;
        end
    endtask

    task automatic classify(logic [20:0] nc);
        bit fits;
        bit at0;
        fits = word_len <= BUF_CHARS;
        at0 = tok_start == 16'd0;
        if (fits && word_listed(1'b0)) begin
            add_span(word_end, ST_KEYWORD);
        end else if (fits && word_listed(1'b1)) begin
            if (nc != CH_RPAR) begin
                decl_line = 1'b1;
            end
            add_span(word_end, ST_TYPE);
        end else begin
            if (at0) begin
                decl_line = 1'b1;
            end
            if (decl_line) begin
                if (nc == CH_LPAR) begin
                    add_span(word_end, ST_FUNCTION);
                end else if (at0) begin
                    add_span(word_end, ST_TYPE);
                end else begin
                    add_span(word_end, ST_VARIABLE);
                end
            end
        end
    endtask

    task automatic start_token(logic [20:0] c, logic [15:0] at);
        phase = LX_SCAN;
        if (c == CH_SLASH) begin
            phase = LX_SLASH;
            tok_start = at;
        end else if (c == CH_DOLLAR) begin
            phase = LX_VAR;
            tok_start = at;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            phase = c == CH_DQUOTE ? LX_DQ : LX_SQ;
            carry_mode = c == CH_DQUOTE ? CM_DQ : CM_SQ;
            escaping = 1'b0;
            tok_start = at;
        end else if (c == CH_EQ) begin
            decl_line = 1'b0;
        end else if (is_letter(c)) begin
            phase = LX_IDENT;
            tok_start = at;
            word_len = 0;
            add_char(c);
        end
    endtask

    task automatic lex_char(logic [20:0] c);
        logic [15:0] at;
        logic [15:0] past;
        at = col;
        past = col < COL_TOP ? col + 16'd1 : col;
        if (c == CH_NL) begin
            case (phase)
                LX_BLOCK, LX_LINE: add_span(at, ST_COMMENT);
                LX_DQ, LX_SQ:      add_span(at, ST_STRING);
                LX_VAR:            add_span(at, ST_VARIABLE);
                LX_IDENT:
                begin
                    word_end = at;
                    classify(c);
                end
                LX_LOOK:           classify(c);
                default:           ;
            endcase
            add_word(KIND_EOL, 16'd0, 16'd0, ST_COMMENT, carry_mode);
            if (phase != LX_BLOCK && phase != LX_DQ && phase != LX_SQ) begin
                phase = LX_SCAN;
            end
            star_seen = 1'b0;
            escaping = 1'b0;
            decl_line = 1'b0;
            tok_start = 16'd0;
            col = 16'd0;
        end else begin
            case (phase)
                LX_SLASH:
                begin
                    if (c == CH_STAR) begin
                        phase = LX_BLOCK;
                        carry_mode = CM_COMMENT;
                        star_seen = 1'b0;
                    end else if (c == CH_SLASH) begin
                        phase = LX_LINE;
                    end else begin
                        start_token(c, at);
                    end
                end
                LX_BLOCK:
                begin
                    if (star_seen && c == CH_SLASH) begin
                        add_span(past, ST_COMMENT);
                        phase = LX_SCAN;
                        carry_mode = CM_NORMAL;
                        star_seen = 1'b0;
                    end else begin
                        star_seen = c == CH_STAR;
                    end
                end
                LX_LINE: ;
                LX_DQ, LX_SQ:
                begin
                    if (escaping) begin
                        escaping = 1'b0;
                    end else if (c == CH_BSLASH) begin
                        escaping = 1'b1;
                    end else if ((c == CH_DQUOTE && phase == LX_DQ) ||
                                 (c == CH_SQUOTE && phase == LX_SQ)) begin
                        add_span(past, ST_STRING);
                        phase = LX_SCAN;
                        carry_mode = CM_NORMAL;
                    end
                end
                LX_VAR:
                begin
                    if (!is_letter(c)) begin
                        add_span(at, ST_VARIABLE);
                        start_token(c, at);
                    end
                end
                LX_IDENT:
                begin
                    if (is_letter(c) || (c >= "0" && c <= "9")) begin
                        add_char(c);
                    end else begin
                        word_end = at;
                        phase = LX_LOOK;
                        if (c != CH_SPACE && c != CH_TAB) begin
                            classify(c);
                            start_token(c, at);
                        end
                    end
                end
                LX_LOOK:
                begin
                    if (c != CH_SPACE && c != CH_TAB) begin
                        classify(c);
                        start_token(c, at);
                    end
                end
                default: start_token(c, at);
            endcase
            col = past;
        end
        if (step_words.size() > 0) begin
            step_words[step_words.size() - 1].last = 1'b1;
        end
        while (step_words.size() > 0) begin
            spans_due.push_back(step_words.pop_front());
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rec_t want;
        if (!rst_n) begin
            carry_mode = CM_NORMAL;
            phase = LX_SCAN;
            star_seen = 1'b0;
            escaping = 1'b0;
            col = 16'd0;
            tok_start = 16'd0;
            word_end = 16'd0;
            word_len = 0;
            decl_line = 1'b0;
            errors = 0;
            pending = 0;
        end else begin
            if (in_valid && in_ready) begin
                lex_char(ch);
            end
            if (out_valid && out_ready) begin
                if (spans_due.size() == 0) begin
                    errors++;
                    $display("%0t: expected no word, actual kind=%0d start=%0d len=%0d style=%0d",
                             $time, kind, span_start, span_len, style);
                end else begin
                    want = spans_due.pop_front();
                    if (kind !== want.kind || span_start !== want.span_start ||
                        span_len !== want.span_len || style !== want.style ||
                        end_state !== want.end_state || last !== want.last) begin
                        errors++;
                        $display("%0t: expected kind=%0d start=%0d len=%0d style=%0d es=%0d last=%0d",
                                 $time, want.kind, want.span_start, want.span_len,
                                 want.style, want.end_state, want.last);
                        $display("%0t:   actual kind=%0d start=%0d len=%0d style=%0d es=%0d last=%0d",
                                 $time, kind, span_start, span_len, style, end_state, last);
                    end
                end
            end
            pending = spans_due.size();
        end
    end

endmodule

### bench/testbench.sv
// Top of the span lexer bench: clock, reset, character stimulus, output pacing and verdict.
module testbench;
    import spl_pkg::*;

    logic        clk;
    logic        rst_n;
    logic [20:0] ch;
    logic        in_valid;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [15:0] span_start;
    logic [15:0] span_len;
    logic [2:0]  style;
    logic [1:0]  end_state;
    logic        last;
    int          errors;
    int          pending;

    // Characters still to be sent, and whether the sender idles between them.
    logic [20:0] text [$];
    bit          paced;

    string sample_words [14] = '{
        "function", "if", "echo", "return", "int", "string", "NULL", "array",
        {"__halt", "_compiler"}, "Int", "foo", "bar_1", {"include", "_once"}, "integer"
    };

    php_syntax_span_lexer DUT (
        .clk(clk), .rst_n(rst_n), .ch(ch), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
        .span_start(span_start), .span_len(span_len), .style(style),
        .end_state(end_state), .last(last)
    );

    span_checker u_checker (
        .clk(clk), .rst_n(rst_n), .ch(ch), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
        .span_start(span_start), .span_len(span_len), .style(style),
        .end_state(end_state), .last(last), .errors(errors), .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever begin
            #5 clk = ~clk;
        end
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    function automatic int pick_gap();
        if (!paced || $urandom_range(0, 9) < 6) begin
            return 0;
        end
        return $urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            text.push_back(21'(s[i]));
        end
    endtask

    task automatic add_letters(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: text.push_back(21'($urandom_range(97, 122)));
                1: text.push_back(21'($urandom_range(65, 90)));
                2: text.push_back(21'h5F);
                default: text.push_back(21'($urandom_range(48, 57)));
            endcase
        end
    endtask

    // Body characters for strings and comments, with quotes, stars and escapes mixed in.
    task automatic add_body(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: text.push_back(CH_BSLASH);
                1: text.push_back(CH_DQUOTE);
                2: text.push_back(CH_SQUOTE);
                3: text.push_back(CH_STAR);
                4: text.push_back(CH_SLASH);
                default: text.push_back(21'($urandom_range(32, 126)));
            endcase
        end
    endtask

    // One PHP-like line built from random fragments; a few fragments are plain noise.
    task automatic add_line();
        int pieces;
        pieces = $urandom_range(0, 8);
        for (int p = 0; p < pieces; p++) begin
            case ($urandom_range(0, 14))
                0, 1: add_text(sample_words[$urandom_range(0, 13)]);
                2:    add_letters($urandom_range(1, 6));
                3:
                begin
                    text.push_back(21'($urandom_range(97, 122)));
                    add_letters($urandom_range(30, 36));
                end
                4:
                begin
                    text.push_back(CH_DOLLAR);
                    add_letters($urandom_range(0, 4));
                end
                5:
                begin
                    text.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                    add_body($urandom_range(0, 6));
                end
                6:
                begin
                    add_text("/*");
                    add_body($urandom_range(0, 6));
                    if ($urandom_range(0, 2) != 0) begin
                        add_text("*/");
                    end
                end
                7:
                begin
                    add_text("//");
                    add_body($urandom_range(0, 4));
                end
                8:
                begin
                    if ($urandom_range(0, 1) != 0) begin
                        add_text(" ");
                    end else begin
                        add_text("\t  ");
                    end
                end
                9:    add_text($urandom_range(0, 1) ? "(" : ")");
                10:   add_text($urandom_range(0, 1) ? "=" : "/");
                11:   text.push_back(21'($urandom_range(0, 21'h1FFFFF)));
                12:   text.push_back(21'($urandom_range(128, 300)));
                default: text.push_back(21'($urandom_range(32, 126)));
            endcase
        end
        text.push_back(CH_NL);
    endtask

    task automatic send_text();
        int gap;
        while (text.size() > 0) begin
            ch = text.pop_front();
            in_valid = 1'b1;
            @(posedge clk);
            while (!in_ready) begin
                @(posedge clk);
            end
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Receiver pacing. Once, early on, it holds off for a long stretch so that
    // the result queue fills and the lexer has to stall its input.
    initial begin
        int run;
        int seen;
        bit held;
        out_ready = 1'b0;
        seen = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && seen > 300) begin
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
                held = 1'b1;
            end
            case ($urandom_range(0, 19))
                0:       begin out_ready = 1'b0; run = $urandom_range(10, 40); end
                1, 2, 3: begin out_ready = 1'b0; run = $urandom_range(1, 3); end
                default: begin out_ready = 1'b1; run = $urandom_range(1, 12); end
            endcase
            repeat (run - 1) @(negedge clk);
            seen += run;
        end
    end

    initial begin
        int sent;
        rst_n = 1'b0;
        ch = '0;
        in_valid = 1'b0;
        paced = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: the comment opener's star does not close it; a comment
        // and a string carried over empty lines; a backslash just before the
        // newline; a lone slash; type and function heuristics; extreme codes.
        add_text("/*/x*/\n/*\n\n*/'a\\\n\n'\n");
        add_text("int f(\n$ab=/x if\t(\n");
        text.push_back(21'h000000);
        text.push_back(21'h1FFFFF);
        text.push_back(CH_NL);
        send_text();

        // Random lines; every few lines the sender switches between idling and not.
        sent = 0;
        while (sent < 1100) begin
            if ($urandom_range(0, 7) == 0) begin
                paced = !paced;
            end
            add_line();
            sent += text.size();
            send_text();
        end
        in_valid = 1'b0;

        do begin
            @(negedge clk);
        end while (pending != 0);
        repeat (20) @(negedge clk);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
